>>> rtl/tbsf_pkg.sv
// shared constants, codes and state type for the typed byte stack
`timescale 1ns / 1ps
package tbsf_pkg;

  localparam int unsigned StackLimit  = 4096;
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned StoreSize   = StackLimit + HeaderBytes;
  localparam int unsigned AddrW       = $clog2(StoreSize);

  typedef logic [AddrW-1:0] addr_t;

  localparam logic [2:0] ReqPush  = 3'd0;
  localparam logic [2:0] ReqPop   = 3'd1;
  localparam logic [2:0] ReqRaw   = 3'd2;
  localparam logic [2:0] ReqEnter = 3'd3;
  localparam logic [2:0] ReqLeave = 3'd4;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatOver  = 2'd1;
  localparam logic [1:0] StatUnder = 2'd2;

  localparam logic [7:0] TypeUntyped = 8'd0;
  localparam logic [7:0] TypeInt     = 8'd1;
  localparam logic [7:0] TypeFloat   = 8'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_HDR,
    ST_WRITE,
    ST_READ,
    ST_HDR_RD,
    ST_HDR_WAIT,
    ST_I2F,
    ST_F2I,
    ST_RESP
  } state_e;

endpackage

>>> rtl/typed_byte_stack_with_frames.sv
// typed byte stack with frames: byte store, sequencer and int/float conversion
// store bytes are accessed one per cycle; the int to float path normalizes with
//   one-place shifts of the accumulator
// in_stall_o is high until the result is loaded, so a new request waits for the last one
// reset: after rst_ni the store is cleared by a pass over all 4100 bytes, one byte
//   a cycle, with in_stall_o high; top pointer and saved base reset to zero
`timescale 1ns / 1ps
module typed_byte_stack_with_frames (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  value_type_i,
  input  logic [31:0] value_in_i,
  input  logic [2:0]  byte_count_i,
  input  logic [11:0] local_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [7:0]  read_type_o
);
  import tbsf_pkg::*;

  localparam logic [13:0] Limit14 = 14'(StackLimit);

  state_e state_q, state_d;
  addr_t  top_q, top_d, ptr_q, ptr_d, clr_q, clr_d;
  logic [31:0] base_q, base_d, acc_q, acc_d, wdata_q, wdata_d;
  logic [2:0]  req_q, req_d, n_q, n_d, cnt_q, cnt_d;
  logic [7:0]  vtype_q, vtype_d, rtype_q, rtype_d;
  logic [1:0]  stat_q, stat_d;
  logic        sign_q, sign_d;
  logic [4:0]  nrm_q, nrm_d;
  logic        ovalid_q, ovalid_d;
  logic [1:0]  ostat_q, ostat_d;
  logic [31:0] oval_q, oval_d;
  logic [7:0]  otype_q, otype_d;

  logic [7:0] mem [StoreSize];
  logic       mem_we;
  addr_t      mem_addr;
  logic [7:0] mem_wdata, rdata_q;

  logic [2:0]  len;
  logic [13:0] top_len, enter_top;
  logic [1:0]  bidx;
  logic [7:0]  f_exp;
  logic [23:0] f_man;
  logic [31:0] f_mag;
  logic        i_rnd;
  addr_t       clamp;

  assign len      = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
  assign top_len  = {1'b0, top_q} + 14'(len);
  assign enter_top = {1'b0, top_q} + 14'(local_bytes_i);
  assign f_exp    = acc_q[30:23];
  assign f_man    = {1'b1, acc_q[22:0]};
  assign f_mag    = (f_exp >= 8'd150) ? ({8'd0, f_man} << (f_exp - 8'd150))
                                      : ({8'd0, f_man} >> (8'd150 - f_exp));
  assign i_rnd    = acc_q[7] & ((|acc_q[6:0]) | acc_q[8]);
  assign clamp    = base_q[31] ? '0
                  : (base_q > 32'(StackLimit)) ? AddrW'(StackLimit)
                  : base_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      top_q    <= '0;
      base_q   <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      base_q   <= base_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    acc_q   <= acc_d;
    wdata_q <= wdata_d;
    req_q   <= req_d;
    n_q     <= n_d;
    cnt_q   <= cnt_d;
    vtype_q <= vtype_d;
    rtype_q <= rtype_d;
    stat_q  <= stat_d;
    sign_q  <= sign_d;
    nrm_q   <= nrm_d;
    ostat_q <= ostat_d;
    oval_q  <= oval_d;
    otype_q <= otype_d;
  end

  always_comb begin
    state_d = state_q;  top_d = top_q;   base_d = base_q;  clr_d = clr_q;
    ptr_d = ptr_q;      acc_d = acc_q;   wdata_d = wdata_q; req_d = req_q;
    n_d = n_q;          cnt_d = cnt_q;   vtype_d = vtype_q; rtype_d = rtype_q;
    stat_d = stat_q;    sign_d = sign_q; nrm_d = nrm_q;
    ostat_d = ostat_q;  oval_d = oval_q; otype_d = otype_q;
    ovalid_d = ovalid_q & out_stall_i;
    mem_we = 1'b0;
    mem_addr = ptr_q + addr_t'(cnt_q);
    mem_wdata = '0;
    bidx = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_q;
        clr_d = clr_q + addr_t'(1);
        if (clr_q == addr_t'(StoreSize - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_i;  vtype_d = value_type_i;
          stat_d = StatOk;     rtype_d = '0;
          acc_d = '0;          cnt_d = '0;
          state_d = ST_RESP;
          case (req_type_i)
            ReqPush: begin
              if (top_len >= Limit14) begin
                stat_d = StatOver;
              end else begin
                wdata_d = value_in_i;
                n_d = len;
                ptr_d = top_q;
                state_d = (value_type_i != TypeUntyped) ? ST_PUSH_HDR : ST_WRITE;
              end
            end
            ReqPop: begin
              if (top_q < addr_t'(len)) begin
                stat_d = StatUnder;
              end else begin
                top_d = top_q - addr_t'(len);
                ptr_d = top_q - addr_t'(len);
                n_d = len;
                state_d = ST_READ;
              end
            end
            ReqRaw: begin
              if (top_q < addr_t'(HeaderBytes)) begin
                stat_d = StatUnder;
              end else begin
                top_d = top_q - addr_t'(4);
                ptr_d = top_q - addr_t'(4);
                n_d = 3'd4;
                state_d = ST_READ;
              end
            end
            ReqEnter: begin
              if (enter_top >= Limit14) begin
                stat_d = StatOver;
              end else begin
                top_d = enter_top[AddrW-1:0];
                base_d = 32'(top_q);
                if (enter_top + 14'd4 < Limit14) begin
                  ptr_d = enter_top[AddrW-1:0];
                  wdata_d = base_q;
                  n_d = 3'd4;
                  state_d = ST_WRITE;
                end
              end
            end
            ReqLeave: begin
              if (top_q >= addr_t'(4)) begin
                ptr_d = top_q - addr_t'(4);
                n_d = 3'd4;
                state_d = ST_READ;
              end else begin
                top_d = clamp;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PUSH_HDR: begin
        mem_we = 1'b1;
        mem_addr = top_q;
        mem_wdata = vtype_q;
        ptr_d = top_q + addr_t'(HeaderBytes);
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        bidx = cnt_q[1:0];
        if (cnt_q < n_q) begin
          mem_we = 1'b1;
          mem_wdata = wdata_q[{bidx, 3'b000} +: 8];
          cnt_d = cnt_q + 3'd1;
        end else begin
          top_d = ptr_q + addr_t'(n_q);
          state_d = ST_RESP;
        end
      end
      ST_READ: begin
        // the store read is registered: each byte comes back in the cycle after its address
        bidx = 2'(cnt_q - 3'd1);
        if (cnt_q != 3'd0) begin
          acc_d[{bidx, 3'b000} +: 8] = rdata_q;
        end
        if (cnt_q < n_q) begin
          cnt_d = cnt_q + 3'd1;
        end else if (req_q == ReqLeave) begin
          // leave answers a zero value
          base_d = acc_d;
          acc_d = '0;
          top_d = clamp;
          state_d = ST_RESP;
        end else if (req_q == ReqRaw || vtype_q != TypeUntyped) begin
          state_d = ST_HDR_RD;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_HDR_RD: begin
        if (top_q < addr_t'(HeaderBytes)) begin
          // header would sit below zero: untyped, stack emptied
          top_d = '0;
          rtype_d = TypeUntyped;
          state_d = ST_RESP;
        end else begin
          top_d = top_q - addr_t'(HeaderBytes);
          mem_addr = top_q - addr_t'(HeaderBytes);
          state_d = ST_HDR_WAIT;
        end
      end
      ST_HDR_WAIT: begin
        state_d = ST_RESP;
        if (req_q == ReqRaw) begin
          rtype_d = rdata_q;
        end else if (rdata_q == TypeInt && vtype_q == TypeFloat) begin
          sign_d = acc_q[31];
          acc_d = acc_q[31] ? (32'd0 - acc_q) : acc_q;
          nrm_d = '0;
          if (acc_q != '0) begin
            state_d = ST_I2F;
          end
        end else if (rdata_q == TypeFloat && vtype_q == TypeInt) begin
          state_d = ST_F2I;
        end
      end
      ST_I2F: begin
        // shift one place a cycle until the leading one reaches the top
        if (acc_q[31]) begin
          acc_d = {sign_q, 8'(8'd158 - 8'(nrm_q)), acc_q[30:8]} + 32'(i_rnd);
          state_d = ST_RESP;
        end else begin
          acc_d = acc_q << 1;
          nrm_d = nrm_q + 5'd1;
        end
      end
      ST_F2I: begin
        if (f_exp >= 8'd158) begin
          acc_d = 32'h8000_0000;
        end else if (f_exp < 8'd127) begin
          acc_d = '0;
        end else begin
          acc_d = acc_q[31] ? (32'd0 - f_mag) : f_mag;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          ostat_d = stat_q;
          oval_d = acc_q;
          otype_d = rtype_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = ovalid_q;
  assign status_o     = ostat_q;
  assign read_value_o = oval_q;
  assign read_type_o  = otype_q;

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= addr_t'(StoreSize - 1))
    else $error("top pointer left the store");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> mem_we && mem_wdata == '0)
    else $error("clearing pass wrote nonzero data");

  a_load_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_stall_i) |=> (!ovalid_q || $past(state_q) == ST_RESP))
    else $error("result register loaded outside the response step");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o)
    else $error("input taken during clearing pass");

endmodule

>>> tb/tb_typed_byte_stack_with_frames.sv
// self-checking testbench for the typed byte stack with frames
`timescale 1ns / 1ps
module tb_typed_byte_stack_with_frames;
  import tbsf_pkg::*;

  localparam int unsigned StoreBytes = StackLimit + HeaderBytes;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [7:0]  vtype;
  } stack_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i = '0;
  logic [7:0]  value_type_i = '0;
  logic [31:0] value_in_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic [11:0] local_bytes_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] read_value_o;
  logic [7:0]  read_type_o;

  // predictor state
  logic [7:0]    mirror_bytes [StoreBytes];
  int unsigned   mirror_top;
  logic [31:0]   mirror_base;
  stack_result_t pending_results [$];

  int unsigned error_count = 0;
  int unsigned hold_off_cycles = 0;
  bit          no_idle = 1'b0;

  typed_byte_stack_with_frames u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [7:0] rd_byte(input int unsigned idx);
    return (idx < StoreBytes) ? mirror_bytes[idx] : 8'h00;
  endfunction

  function automatic void wr_byte(input int unsigned idx, input logic [7:0] v);
    if (idx < StoreBytes) mirror_bytes[idx] = v;
  endfunction

  function automatic logic [31:0] rd_word(input int unsigned idx, input int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = rd_byte(idx + i);
    return v;
  endfunction

  // int32 to float32, round to nearest even
  function automatic logic [31:0] int_to_float(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] m;
    logic [31:0] rem;
    logic [31:0] half;
    int          p;
    int          sh;
    int          ex;
    if (v == '0) return '0;
    mag = v[31] ? -v : v;
    p = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) p = i;
    ex = 127 + p;
    if (p <= 23) begin
      m = mag << (23 - p);
    end else begin
      sh = p - 23;
      m = mag >> sh;
      rem = mag & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      if (rem > half || (rem == half && m[0])) m = m + 1;
      if (m == 32'h0100_0000) begin
        m = m >> 1;
        ex++;
      end
    end
    return {v[31], ex[7:0], m[22:0]};
  endfunction

  // float32 to int32, truncate; nan and out of range give the minimum int
  function automatic logic [31:0] float_to_int(input logic [31:0] v);
    logic [31:0] mag;
    int          e;
    if (v[30:23] == 8'hff) return 32'h8000_0000;
    e = int'(v[30:23]) - 127;
    if (e < 0) return '0;
    if (e >= 31) return 32'h8000_0000;
    mag = {8'h00, 1'b1, v[22:0]};
    mag = (e >= 23) ? (mag << (e - 23)) : (mag >> (23 - e));
    return v[31] ? -mag : mag;
  endfunction

  function automatic logic [7:0] pop_type_header();
    if (mirror_top < HeaderBytes) begin
      mirror_top = 0;
      return TypeUntyped;
    end
    mirror_top -= HeaderBytes;
    return rd_byte(mirror_top);
  endfunction

  function automatic stack_result_t apply_request(input logic [2:0] req, input logic [7:0] vt,
                                                  input logic [31:0] vin, input logic [2:0] cnt,
                                                  input logic [11:0] locals);
    stack_result_t r;
    int unsigned   len;
    int unsigned   prev;
    int unsigned   next;
    logic [31:0]   prev_base;
    logic [7:0]    stored;
    r = '0;
    len = (cnt > 3'd4) ? 4 : int'(cnt);
    case (req)
      ReqPush: begin
        if (mirror_top + len >= StackLimit) begin
          r.status = StatOver;
        end else begin
          if (vt != TypeUntyped) begin
            wr_byte(mirror_top, vt);
            mirror_top += HeaderBytes;
          end
          for (int i = 0; i < len; i++) wr_byte(mirror_top + i, vin[8*i +: 8]);
          mirror_top += len;
        end
      end
      ReqPop: begin
        if (mirror_top < len) begin
          r.status = StatUnder;
        end else begin
          mirror_top -= len;
          r.value = rd_word(mirror_top, len);
          if (vt != TypeUntyped) begin
            stored = pop_type_header();
            if (stored == TypeInt && vt == TypeFloat) r.value = int_to_float(r.value);
            else if (stored == TypeFloat && vt == TypeInt) r.value = float_to_int(r.value);
          end
        end
      end
      ReqRaw: begin
        if (mirror_top < 4) begin
          r.status = StatUnder;
        end else begin
          mirror_top -= 4;
          r.value = rd_word(mirror_top, 4);
          r.vtype = pop_type_header();
        end
      end
      ReqEnter: begin
        prev = mirror_top;
        next = mirror_top + locals;
        if (next >= StackLimit) begin
          r.status = StatOver;
        end else begin
          mirror_top = next;
          if (next + 4 < StackLimit) begin
            for (int i = 0; i < 4; i++) wr_byte(mirror_top + i, mirror_base[8*i +: 8]);
            mirror_top += 4;
          end
          mirror_base = prev;
        end
      end
      ReqLeave: begin
        prev_base = mirror_base;
        if (mirror_top >= 4) begin
          mirror_top -= 4;
          mirror_base = rd_word(mirror_top, 4);
        end
        if (prev_base[31]) mirror_top = 0;
        else if (prev_base > StackLimit) mirror_top = StackLimit;
        else mirror_top = prev_base;
      end
      default: ;
    endcase
    return r;
  endfunction

  // one request: idle gap, offer, wait for the transfer, then predict
  task automatic send_request(input logic [2:0] req, input logic [7:0] vt,
                              input logic [31:0] vin, input logic [2:0] cnt,
                              input logic [11:0] locals);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    value_type_i  <= vt;
    value_in_i    <= vin;
    byte_count_i  <= cnt;
    local_bytes_i <= locals;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_request(req, vt, vin, cnt, locals));
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
  endtask

  // result side: stall draw per transfer, optional long hold-off
  initial begin
    int            stall_left;
    stack_result_t exp_r;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = pending_results.pop_front();
          if (status_o !== exp_r.status)
            report_mismatch($sformatf("status %0d exp %0d", status_o, exp_r.status));
          if (read_value_o !== exp_r.value)
            report_mismatch($sformatf("value %h exp %h", read_value_o, exp_r.value));
          if (read_type_o !== exp_r.vtype)
            report_mismatch($sformatf("type %0d exp %0d", read_type_o, exp_r.vtype));
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_push_pop_extremes();
    send_request(ReqPop, TypeUntyped, '0, 3'd1, '0);          // underflow on empty
    send_request(ReqRaw, TypeUntyped, '0, 3'd4, '0);          // raw underflow
    send_request(ReqPush, TypeUntyped, 32'hffff_ffff, 3'd7, '0);  // long length
    send_request(ReqPop, TypeUntyped, '0, 3'd2, '0);
    send_request(ReqPop, TypeUntyped, '0, 3'd2, '0);
    send_request(ReqPush, 8'hff, 32'hdead_beef, 3'd4, 12'hfff);
    send_request(ReqRaw, TypeUntyped, '0, 3'd0, '0);
    send_request(ReqPush, TypeUntyped, 32'h0000_00a5, 3'd1, '0);
    send_request(ReqPop, TypeFloat, '0, 3'd1, '0);            // header below zero
    send_request(ReqPush, TypeInt, '0, 3'd0, '0);
    send_request(ReqPop, TypeInt, '0, 3'd0, '0);
    send_request(3'd7, 8'hff, 32'hffff_ffff, 3'd7, 12'hfff);  // unknown request
    send_request(3'd5, TypeUntyped, '0, '0, '0);
  endtask

  task automatic test_conversions();
    send_request(ReqPush, TypeInt, 32'h8000_0000, 3'd4, '0);
    send_request(ReqPop, TypeFloat, '0, 3'd4, '0);
    send_request(ReqPush, TypeInt, 32'h0100_0003, 3'd4, '0);  // rounds to even
    send_request(ReqPop, TypeFloat, '0, 3'd4, '0);
    send_request(ReqPush, TypeFloat, 32'h7fc0_0000, 3'd4, '0);  // nan
    send_request(ReqPop, TypeInt, '0, 3'd4, '0);
    send_request(ReqPush, TypeFloat, 32'hc2f6_e666, 3'd4, '0);  // -123.45
    send_request(ReqPop, TypeInt, '0, 3'd4, '0);
    send_request(ReqPush, TypeFloat, 32'h4f00_0000, 3'd4, '0);  // 2^31 out of range
    send_request(ReqPop, TypeInt, '0, 3'd4, '0);
  endtask

  task automatic test_frames();
    send_request(ReqEnter, TypeUntyped, '0, '0, 12'd16);
    send_request(ReqEnter, TypeUntyped, '0, '0, 12'hfff);     // bound rejected
    send_request(ReqLeave, TypeUntyped, '0, '0, '0);
    send_request(ReqLeave, TypeUntyped, '0, '0, '0);
    // base past the limit, then a leave clamps it
    send_request(ReqPush, TypeUntyped, 32'h8000_0000, 3'd4, '0);
    send_request(ReqLeave, TypeUntyped, '0, '0, '0);
    send_request(ReqLeave, TypeUntyped, '0, '0, '0);
  endtask

  function automatic logic [7:0] draw_type();
    case ($urandom_range(0, 5))
      0, 1: return TypeInt;
      2, 3: return TypeFloat;
      4:    return TypeUntyped;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_request();
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    v = ($urandom_range(0, 3) == 0) ? 32'($signed(16'($urandom))) : $urandom;
    if (pick < 40)
      send_request(ReqPush, draw_type(), v, ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'd4,
                   12'($urandom));
    else if (pick < 70)
      send_request(ReqPop, draw_type(), $urandom, 3'($urandom), 12'($urandom));
    else if (pick < 80)
      send_request(ReqRaw, 8'($urandom), $urandom, 3'($urandom), 12'($urandom));
    else if (pick < 88)
      send_request(ReqEnter, 8'($urandom), $urandom, 3'($urandom),
                   ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)));
    else if (pick < 97)
      send_request(ReqLeave, 8'($urandom), $urandom, 3'($urandom), 12'($urandom));
    else
      send_request(3'($urandom_range(5, 7)), 8'($urandom), $urandom, 3'($urandom),
                   12'($urandom));
  endtask

  task automatic test_random(input int count);
    int run_len;
    int next_mode;
    next_mode = 0;
    for (int i = 0; i < count; i++) begin
      // stretches with no idling on either side
      if (i >= next_mode) begin
        no_idle = ($urandom_range(0, 2) == 0);
        next_mode = i + 200;
      end
      // runs of pushes of drawn types fill the stack toward the limit
      if (i == count / 2 || $urandom_range(0, 400) == 0) begin
        run_len = $urandom_range(550, 700);
        if (run_len > count - i) run_len = count - i;
        repeat (run_len) send_request(ReqPush, draw_type(), $urandom, 3'd4, '0);
        i += run_len;
      end
      random_request();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 300;
    repeat (6) random_request();
  endtask

  initial begin
    for (int i = 0; i < StoreBytes; i++) mirror_bytes[i] = 8'h00;
    mirror_top = 0;
    mirror_base = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_push_pop_extremes();
    test_conversions();
    test_frames();
    test_backpressure();
    test_random(1200);
    go_quiet();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
